[design/fpsa_pkg.sv]
// fpsa_pkg: shared constants and types for the free page stack allocator
// status codes, command codes and fixed field widths
// used by free_page_stack_allocator and fpsa_checker
`default_nettype none

package fpsa_pkg;

	localparam int ADDR_W   = 32;
	localparam int CFG_W    = 20;
	localparam int STATUS_W = 2;

	typedef logic [STATUS_W-1:0] status_t;
	typedef logic [ADDR_W-1:0]   addr_t;

	localparam status_t ST_OK      = 2'd0;
	localparam status_t ST_IGNORED = 2'd1;
	localparam status_t ST_OOM     = 2'd2;
	localparam status_t ST_DROPPED = 2'd3;

	localparam logic CMD_ALLOC = 1'b0;
	localparam logic CMD_FREE  = 1'b1;

	localparam logic [CFG_W-1:0] BUMP_RESET = 20'd256;

endpackage

`default_nettype wire

[design/free_page_stack_allocator.sv]
// Free page stack allocator. Before the first kept free, an alloc takes the
// next page of a bump pointer (loaded by a cfg_data write) and answers in
// the cycle after the input transfer, as do frees and allocs that report
// out of memory. Once a page has been kept, allocs come from a free stack
// memory of ENTRIES_PER_PAGE*MAX_BACKING entries or from a backing page
// memory of MAX_BACKING entries; both have a synchronous read, so such an
// alloc goes through the READ state and a memory read register. One item is
// in work at a time; the next item is taken as soon as the output register
// can take its result. Both memories start undefined and need no clearing
// pass after reset. Addresses are page numbers shifted up by PAGE_SHIFT.
// depends on fpsa_pkg
`default_nettype none

module free_page_stack_allocator #(
	parameter int ENTRIES_PER_PAGE = 1024,
	parameter int MAX_BACKING      = 16,
	parameter int PAGE_SHIFT       = 12
) (
	input  wire                           clk,
	input  wire                           arst_n,
	input  wire                           cfg_valid,
	output logic                          cfg_ready,
	input  wire  [fpsa_pkg::CFG_W-1:0]    cfg_data,
	input  wire                           in_valid,
	output logic                          in_stall,
	input  wire                           cmd,
	input  wire  [fpsa_pkg::ADDR_W-1:0]   page_addr,
	output logic                          out_valid,
	input  wire                           out_stall,
	output logic [fpsa_pkg::ADDR_W-1:0]   addr,
	output logic [fpsa_pkg::STATUS_W-1:0] status
);

	localparam int PW    = fpsa_pkg::ADDR_W - PAGE_SHIFT;
	localparam int DEPTH = ENTRIES_PER_PAGE * MAX_BACKING;
	localparam int SA_W  = $clog2(DEPTH);
	localparam int SC_W  = $clog2(DEPTH + 1);
	localparam int BA_W  = (MAX_BACKING > 1) ? $clog2(MAX_BACKING) : 1;
	localparam int BC_W  = $clog2(MAX_BACKING + 1);

	localparam logic [SC_W-1:0] EPP_C  = SC_W'(ENTRIES_PER_PAGE);
	localparam logic [BC_W-1:0] MAXB_C = BC_W'(MAX_BACKING);

	localparam logic S_IDLE = 1'b0;
	localparam logic S_READ = 1'b1;

	// state
	logic            state_q;
	logic            running_q;
	logic [PW-1:0]   bump_q;
	logic [SC_W-1:0] sc_q;
	logic [BC_W-1:0] bc_q;
	logic            rd_bk_s1;

	// memories
	logic [PW-1:0] stack_mem [DEPTH];
	logic [PW-1:0] back_mem  [MAX_BACKING];
	logic [PW-1:0] stk_rd_q;
	logic [PW-1:0] bk_rd_q;

	// output register
	logic                      out_valid_q;
	fpsa_pkg::addr_t           addr_q;
	fpsa_pkg::status_t         status_q;

	logic            in_fire;
	logic            out_free;
	logic [PW-1:0]   page_num;
	logic            below_bump;
	logic [SC_W-1:0] cap_full;
	logic [SC_W-1:0] cap_less;
	logic [SC_W-1:0] sc_m1;
	logic [BC_W-1:0] bc_m1;

	logic                ld_now;
	fpsa_pkg::addr_t     ld_addr;
	fpsa_pkg::status_t   ld_status;
	logic                go_rd;
	logic                stk_re;
	logic                stk_we;
	logic                bk_re;
	logic                bk_we;
	logic                bump_inc;
	logic                set_run;
	logic                rd_done;

	assign cfg_ready = 1'b1;
	assign out_free  = !out_valid_q || !out_stall;
	assign in_stall  = (state_q != S_IDLE) || !out_free;
	assign in_fire   = in_valid && !in_stall;
	assign rd_done   = (state_q == S_READ) && out_free;

	assign out_valid = out_valid_q;
	assign addr      = addr_q;
	assign status    = status_q;

	assign page_num   = page_addr[fpsa_pkg::ADDR_W-1:PAGE_SHIFT];
	assign below_bump = {1'b0, page_num} < ({1'b0, bump_q} + (PW+1)'(1));
	assign cap_full   = SC_W'(bc_q) * EPP_C;
	assign cap_less   = cap_full - EPP_C;
	assign sc_m1      = sc_q - SC_W'(1);
	assign bc_m1      = bc_q - BC_W'(1);

	always_comb begin
		ld_now    = 1'b0;
		ld_addr   = '0;
		ld_status = fpsa_pkg::ST_OK;
		go_rd     = 1'b0;
		stk_re    = 1'b0;
		stk_we    = 1'b0;
		bk_re     = 1'b0;
		bk_we     = 1'b0;
		bump_inc  = 1'b0;
		set_run   = 1'b0;
		if (in_fire) begin
			if (cmd == fpsa_pkg::CMD_ALLOC) begin
				priority if (!running_q) begin
					ld_now   = 1'b1;
					ld_addr  = {bump_q, {PAGE_SHIFT{1'b0}}};
					bump_inc = 1'b1;
				end else if (sc_q == '0) begin
					ld_now    = 1'b1;
					ld_status = fpsa_pkg::ST_OOM;
				end else if (bc_q != '0 && sc_q < cap_less) begin
					go_rd = 1'b1;
					bk_re = 1'b1;
				end else begin
					go_rd  = 1'b1;
					stk_re = 1'b1;
				end
			end else begin
				ld_now = 1'b1;
				priority if (below_bump) begin
					ld_status = fpsa_pkg::ST_IGNORED;
				end else if (sc_q >= cap_full) begin
					if (bc_q >= MAXB_C) begin
						ld_status = fpsa_pkg::ST_DROPPED;
					end else begin
						bk_we   = 1'b1;
						set_run = 1'b1;
					end
				end else begin
					stk_we  = 1'b1;
					set_run = 1'b1;
				end
			end
		end
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			running_q   <= 1'b0;
			bump_q      <= PW'(fpsa_pkg::BUMP_RESET);
			sc_q        <= '0;
			bc_q        <= '0;
			out_valid_q <= 1'b0;
			rd_bk_s1    <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				bump_q <= PW'(cfg_data);
			end else if (bump_inc) begin
				bump_q <= bump_q + PW'(1);
			end
			if (set_run) begin
				running_q <= 1'b1;
			end
			if (stk_we) begin
				sc_q <= sc_q + SC_W'(1);
			end else if (stk_re) begin
				sc_q <= sc_m1;
			end
			if (bk_we) begin
				bc_q <= bc_q + BC_W'(1);
			end else if (bk_re) begin
				bc_q <= bc_m1;
			end
			if (go_rd) begin
				state_q  <= S_READ;
				rd_bk_s1 <= bk_re;
			end else if (rd_done) begin
				state_q <= S_IDLE;
			end
			if (ld_now || rd_done) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (ld_now) begin
			addr_q   <= ld_addr;
			status_q <= ld_status;
		end else if (rd_done) begin
			addr_q   <= {(rd_bk_s1 ? bk_rd_q : stk_rd_q), {PAGE_SHIFT{1'b0}}};
			status_q <= fpsa_pkg::ST_OK;
		end
	end

	// free stack memory
	always_ff @(posedge clk) begin
		if (stk_we) begin
			stack_mem[sc_q[SA_W-1:0]] <= page_num;
		end
		if (stk_re) begin
			stk_rd_q <= stack_mem[sc_m1[SA_W-1:0]];
		end
	end

	// backing page memory
	always_ff @(posedge clk) begin
		if (bk_we) begin
			back_mem[bc_q[BA_W-1:0]] <= page_num;
		end
		if (bk_re) begin
			bk_rd_q <= back_mem[bc_m1[BA_W-1:0]];
		end
	end

endmodule

`default_nettype wire

[design/fpsa_checker.sv]
// fpsa_checker: port-level checks on free_page_stack_allocator results
// depends on fpsa_pkg; bound to the top level below
`default_nettype none

module fpsa_checker (
	input wire                           clk,
	input wire                           arst_n,
	input wire                           in_valid,
	input wire                           in_stall,
	input wire                           cmd,
	input wire                           out_valid,
	input wire                           out_stall,
	input wire [fpsa_pkg::ADDR_W-1:0]   addr,
	input wire [fpsa_pkg::STATUS_W-1:0] status
);

	// a free answers in the next cycle, never with an address or out of memory
	a_free_result: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && cmd == fpsa_pkg::CMD_FREE |=>
			out_valid && addr == '0 && status != fpsa_pkg::ST_OOM)
		else $error("free transfer without matching result");

	// only a successful alloc carries an address
	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != fpsa_pkg::ST_OK |-> addr == '0)
		else $error("failed result with nonzero addr");

	// handed out addresses have their low 8 bits clear
	a_aligned: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> addr[7:0] == 8'd0)
		else $error("unaligned addr");

	// stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(addr) && $stable(status))
		else $error("stalled result changed");

endmodule

bind free_page_stack_allocator fpsa_checker u_fpsa_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_stall  (in_stall),
	.cmd       (cmd),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.addr      (addr),
	.status    (status)
);

`default_nettype wire
